@@ src/multi_slot_timer_table_assert.svh @@
// Assertion macros shared by the timer table sources.
`ifndef MULTI_SLOT_TIMER_TABLE_ASSERT_SVH
`define MULTI_SLOT_TIMER_TABLE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MSTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MSTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mstt_pkg.sv @@
package mstt_pkg;

  localparam int NumSlots = 16;
  localparam int IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int CntW     = $clog2(NumSlots + 1);
  localparam int TimeW    = 31;
  localparam int IdW      = 32;
  localparam int RemW     = 33;
  localparam int ModStepW = $clog2(TimeW);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    RES_ADD    = 2'd0,
    RES_CANCEL = 2'd1,
    RES_FIRED  = 2'd2,
    RES_NONE   = 2'd3
  } res_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [RemW-1:0]  rem;
    logic [TimeW-1:0] period;
    logic             repeats;
  } slot_t;

endpackage

@@ src/mstt_mod.sv @@
module mstt_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mstt_pkg::TimeW-1:0] x_i,
  input  logic [mstt_pkg::TimeW-1:0] p_i,
  output logic                      done_o,
  output logic [mstt_pkg::TimeW-1:0] rem_o
);
  import mstt_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [ModStepW-1:0] step_q, step_d;
  logic [TimeW-1:0]    x_q, x_d;
  logic [TimeW-1:0]    p_q, p_d;
  logic [TimeW-1:0]    acc_q, acc_d;
  logic [TimeW:0]      trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    x_d    = x_q;
    p_d    = p_q;
    acc_d  = acc_q;
    trial  = {acc_q, x_q[TimeW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = ModStepW'(TimeW - 1);
      x_d    = x_i;
      p_d    = p_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, p_q}) begin
        trial = trial - {1'b0, p_q};
      end
      acc_d = trial[TimeW-1:0];
      x_d   = {x_q[TimeW-2:0], 1'b0};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    p_q   <= p_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign rem_o  = acc_q;

`include "multi_slot_timer_table_assert.svh"

  `MSTT_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "mod done longer than one cycle")
  `MSTT_ASSERT(a_acc_below_p, !(busy_q && !start_i && step_q != ModStepW'(TimeW - 1)) || (acc_q < p_q), "remainder not below divisor")
  `MSTT_ASSERT_NEXT(a_done_after_busy, done_d, !busy_q, "busy after done")

endmodule

@@ src/multi_slot_timer_table.sv @@
// channel | valid      | stall        | payload
// in      | in_valid_i | in_stall_o   | req_type, delay_time, period_time, is_periodic,
//         |            |              | target_id, elapsed_time
// out     | out_valid_o| out_stall_i  | result_kind, timer_id, last_result
//
// Add is handled in the idle state. Cancel and tick read and evaluate each used slot,
// and tick sends each periodic reload through the bit-serial remainder unit.
// Slots sit in one memory with registered read; used slots are a prefix
// tracked by a fill count, so reset needs no clearing pass.
// Output stall holds the walk only where a fire beat or the closing result beat must go out.
module multi_slot_timer_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [mstt_pkg::TimeW-1:0] delay_time_i,
  input  logic [mstt_pkg::TimeW-1:0] period_time_i,
  input  logic                       is_periodic_i,
  input  logic [mstt_pkg::IdW-1:0]   target_id_i,
  input  logic [mstt_pkg::TimeW-1:0] elapsed_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 result_kind_o,
  output logic [mstt_pkg::IdW-1:0]   timer_id_o,
  output logic                       last_result_o
);
  import mstt_pkg::*;

  slot_t mem [NumSlots];
  slot_t rd_q;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, r_q, r_d, w_q, w_d;
  logic            tick_q, tick_d;
  logic [IdW-1:0]  tgt_q, tgt_d;
  logic [TimeW-1:0] el_q, el_d;
  logic            hold_v_q, hold_v_d;
  logic [IdW-1:0]  hold_id_q, hold_id_d;
  logic [IdW-1:0]  nfid_q, nfid_d;

  logic            out_v_q, out_v_d;
  res_e            out_kind_q, out_kind_d;
  logic [IdW-1:0]  out_id_q, out_id_d;
  logic            out_last_q, out_last_d;
  logic            out_load, out_free;

  logic            we, rd_en;
  logic [IdxW-1:0] wa;
  slot_t           wd;

  logic            accept, add_ok, fire, advance;
  logic signed [RemW:0] rem_new, rem_neg;
  logic            mod_start, mod_done;
  logic [TimeW-1:0] mod_rem;
  logic [CntW-1:0] r_inc;

  assign out_free = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept = in_valid_i && !in_stall_o;

  assign rem_new = $signed({rd_q.rem[RemW-1], rd_q.rem}) - $signed({3'b000, el_q});
  assign rem_neg = -rem_new;
  assign fire    = rem_new[RemW] || (rem_new == '0);
  assign add_ok  = !(is_periodic_i && period_time_i == '0) && (cnt_q != CntW'(NumSlots));
  assign r_inc   = r_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    r_d        = r_q;
    w_d        = w_q;
    tick_d     = tick_q;
    tgt_d      = tgt_q;
    el_d       = el_q;
    hold_v_d   = hold_v_q;
    hold_id_d  = hold_id_q;
    nfid_d     = nfid_q;
    out_load   = 1'b0;
    out_kind_d = out_kind_q;
    out_id_d   = out_id_q;
    out_last_d = out_last_q;
    we         = 1'b0;
    wa         = w_q[IdxW-1:0];
    wd         = rd_q;
    rd_en      = 1'b0;
    mod_start  = 1'b0;
    advance    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_ADD: begin
              out_load   = 1'b1;
              out_kind_d = RES_ADD;
              out_last_d = 1'b1;
              out_id_d   = '0;
              if (add_ok) begin
                out_id_d   = nfid_q;
                we         = 1'b1;
                wa         = cnt_q[IdxW-1:0];
                wd.id      = nfid_q;
                wd.rem     = {2'b00, delay_time_i};
                wd.period  = period_time_i;
                wd.repeats = is_periodic_i;
                cnt_d      = cnt_q + 1'b1;
                nfid_d     = (nfid_q == '1) ? IdW'(1) : nfid_q + 1'b1;
              end
            end
            REQ_CANCEL, REQ_TICK: begin
              tick_d   = (req_type_i == REQ_TICK);
              tgt_d    = target_id_i;
              el_d     = elapsed_time_i;
              hold_v_d = 1'b0;
              r_d      = '0;
              w_d      = '0;
              state_d  = (cnt_q == '0) ? ST_FIN : ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_EV;
      end
      ST_EV: begin
        if (!tick_q) begin
          if (rd_q.id != tgt_q) begin
            we  = 1'b1;
            w_d = w_q + 1'b1;
          end
          advance = 1'b1;
        end else if (!fire) begin
          we      = 1'b1;
          wd.rem  = rem_new[RemW-1:0];
          w_d     = w_q + 1'b1;
          advance = 1'b1;
        end else if (!hold_v_q || out_free) begin
          if (hold_v_q) begin
            out_load   = 1'b1;
            out_kind_d = RES_FIRED;
            out_id_d   = hold_id_q;
            out_last_d = 1'b0;
          end
          hold_v_d  = 1'b1;
          hold_id_d = rd_q.id;
          if (rd_q.repeats && rd_q.period != '0) begin
            mod_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            advance = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          we      = 1'b1;
          wd.rem  = {2'b00, rd_q.period} - {2'b00, mod_rem};
          w_d     = w_q + 1'b1;
          advance = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          if (!tick_q) begin
            out_kind_d = RES_CANCEL;
            out_id_d   = '0;
          end else if (hold_v_q) begin
            out_kind_d = RES_FIRED;
            out_id_d   = hold_id_q;
          end else begin
            out_kind_d = RES_NONE;
            out_id_d   = '0;
          end
          hold_v_d = 1'b0;
          cnt_d    = w_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (advance) begin
      r_d     = r_inc;
      state_d = (r_inc == cnt_q) ? ST_FIN : ST_RD;
    end
  end

  always_comb begin
    out_v_d = out_load ? 1'b1 : (out_v_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[r_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      r_q      <= '0;
      w_q      <= '0;
      tick_q   <= 1'b0;
      hold_v_q <= 1'b0;
      nfid_q   <= IdW'(1);
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      r_q      <= r_d;
      w_q      <= w_d;
      tick_q   <= tick_d;
      hold_v_q <= hold_v_d;
      nfid_q   <= nfid_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    el_q      <= el_d;
    hold_id_q <= hold_id_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_last_q <= out_last_d;
    end
  end

  mstt_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (rem_neg[TimeW-1:0]),
    .p_i     (rd_q.period),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign out_valid_o   = out_v_q;
  assign result_kind_o = out_kind_q;
  assign timer_id_o    = out_id_q;
  assign last_result_o = out_last_q;

`include "multi_slot_timer_table_assert.svh"

  `MSTT_ASSERT(a_cnt_range, cnt_q <= CntW'(NumSlots), "fill count beyond table size")
  `MSTT_ASSERT(a_w_le_r, (state_q == ST_IDLE) || (w_q <= r_q), "compaction write ahead of read")
  `MSTT_ASSERT(a_nfid_nonzero, nfid_q != '0, "next id is zero")
  `MSTT_ASSERT_NEXT(a_hold_clear, state_q == ST_FIN && out_free, !hold_v_q, "held fire survives tick")

endmodule
